// ===== rtl/acfr_pkg.sv =====
// Package for the addressed command frame receiver.
// Holds command byte codes, event codes and register indexes.
// No dependencies; imported by addressed_command_frame_receiver.
package acfr_pkg;

  localparam logic [7:0] CMD_POLL      = 8'h80;
  localparam logic [7:0] CMD_TIME_SYNC = 8'h81;
  localparam logic [7:0] CMD_CALL      = 8'h82;
  localparam logic [7:0] CMD_MASK      = 8'h82;
  localparam logic [7:0] BYTE_BCAST    = 8'h01;
  localparam logic [7:0] BYTE_END      = 8'hFE;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_TIME_BYTE = 3'd1;
  localparam logic [2:0] EV_CALL_BYTE = 3'd2;
  localparam logic [2:0] EV_TIME_DONE = 3'd3;
  localparam logic [2:0] EV_CALL_DONE = 3'd4;
  localparam logic [2:0] EV_POLLED    = 3'd5;

  localparam logic REG_STATION_ADDR = 1'b0;

  typedef struct packed {
    logic [2:0] event_res;
    logic [6:0] byte_position;
    logic [7:0] data_byte;
  } acfr_result_t;

endpackage

// ===== rtl/addressed_command_frame_receiver.sv =====
// Addressed command frame receiver: command decode, poll match, frame payload tracking.
// Depends on acfr_pkg for byte codes, event codes and the result struct.
// The result of each accepted request is registered in the output register.
// Throughput: one byte per cycle; the output register frees as it drains, so
// s_axis_tready stays high whenever the result register is empty or being taken.
// Reset (async, active low): idle mode, position zero, station address 1, no result.
module addressed_command_frame_receiver
  import acfr_pkg::*;
#(
  parameter int TIME_FRAME_LEN = 16,
  parameter int CALL_FRAME_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [14:8] byte_position, [15] zero
  output logic [2:0]  m_axis_tuser    // [2:0] event_res
);

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_WAIT_STATION = 3'd1,
    MODE_TIME_WAIT    = 3'd3,
    MODE_TIME_RECV    = 3'd4,
    MODE_CALL_WAIT    = 3'd5,
    MODE_CALL_RECV    = 3'd6
  } mode_e;

  localparam logic [6:0] TimeLimit = 7'(TIME_FRAME_LEN);
  localparam logic [6:0] CallLimit = 7'(CALL_FRAME_LEN);

  mode_e        mode_q, mode_d;
  logic [6:0]   pos_q, pos_d;
  logic [7:0]   station_q;
  logic         out_valid_q;
  acfr_result_t res_q, res_d;

  logic       in_accept;
  logic       cfg_write;
  logic [7:0] rx_byte;
  logic       is_cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == REG_STATION_ADDR) ? {24'd0, station_q} : 32'd0;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata;
  assign is_cmd        = ((rx_byte & CMD_MASK) == CMD_POLL) || (rx_byte == CMD_CALL);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.byte_position, res_q.data_byte};
  assign m_axis_tuser  = res_q.event_res;

  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    res_d  = '{event_res: EV_NONE, byte_position: 7'd0, data_byte: 8'd0};
    if (is_cmd) begin
      if (rx_byte == CMD_POLL) begin
        mode_d = MODE_WAIT_STATION;
      end else if (rx_byte == CMD_TIME_SYNC) begin
        mode_d = MODE_TIME_WAIT;
      end else if (rx_byte == CMD_CALL) begin
        mode_d = MODE_CALL_WAIT;
      end
    end else begin
      unique case (mode_q)
        MODE_WAIT_STATION: begin
          if (station_q != 8'd0 && (station_q - 8'd1) == rx_byte) begin
            res_d.event_res = EV_POLLED;
          end
          mode_d = MODE_IDLE;
        end
        MODE_TIME_WAIT: begin
          if (rx_byte == BYTE_BCAST) begin
            mode_d = MODE_TIME_RECV;
            pos_d  = 7'd0;
          end
        end
        MODE_CALL_WAIT: begin
          if (rx_byte == BYTE_BCAST) begin
            mode_d = MODE_CALL_RECV;
            pos_d  = 7'd0;
          end
        end
        MODE_TIME_RECV: begin
          res_d.byte_position = pos_q;
          if (rx_byte == BYTE_END || pos_q >= TimeLimit) begin
            res_d.event_res = EV_TIME_DONE;
            mode_d          = MODE_IDLE;
          end else begin
            res_d.event_res = EV_TIME_BYTE;
            res_d.data_byte = rx_byte;
            pos_d           = pos_q + 7'd1;
          end
        end
        MODE_CALL_RECV: begin
          res_d.byte_position = pos_q;
          if (rx_byte == BYTE_END || pos_q >= CallLimit) begin
            res_d.event_res = EV_CALL_DONE;
            mode_d          = MODE_IDLE;
          end else begin
            res_d.event_res = EV_CALL_BYTE;
            res_d.data_byte = rx_byte;
            pos_d           = pos_q + 7'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pos_q       <= 7'd0;
      station_q   <= 8'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_STATION_ADDR) begin
        station_q <= pwdata[7:0];
      end
      if (in_accept) begin
        mode_q      <= mode_d;
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== tb/tb_addressed_command_frame_receiver.sv =====
`timescale 1ns / 1ps
// Testbench for the addressed command frame receiver: stream requests in, event results out.
// Predicts every event in a small tracker class and compares field by field.
// Depends on acfr_pkg and the addressed_command_frame_receiver RTL.
module tb_addressed_command_frame_receiver;
  import acfr_pkg::*;

  localparam int TIME_LEN = 16;
  localparam int CALL_LEN = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] STATION_ADDR_OFFSET = 3'(REG_STATION_ADDR) << 2;

  typedef enum logic [2:0] {
    RX_IDLE         = 3'd0,
    RX_WAIT_STATION = 3'd1,
    RX_TIME_WAIT    = 3'd3,
    RX_TIME_RECV    = 3'd4,
    RX_CALL_WAIT    = 3'd5,
    RX_CALL_RECV    = 3'd6
  } rx_mode_e;

  class frame_event_tracker;
    logic [7:0]   station;
    rx_mode_e     mode;
    logic [6:0]   position;
    acfr_result_t pending_events[$];
    int           failures;

    function new();
      station  = 8'd1;
      mode     = RX_IDLE;
      position = '0;
      failures = 0;
    endfunction

    function void take_payload(input logic [7:0] b, input int limit,
                               input logic [2:0] ev_byte, input logic [2:0] ev_done,
                               inout acfr_result_t r);
      r.byte_position = position;
      if (b == BYTE_END || int'(position) >= limit) begin
        r.event_res = ev_done;
        mode        = RX_IDLE;
      end else begin
        r.event_res = ev_byte;
        r.data_byte = b;
        position    = position + 7'd1;
      end
    endfunction

    function void note_byte(input logic [7:0] b);
      acfr_result_t r;
      r = '0;
      r.event_res = EV_NONE;
      if ((b & CMD_MASK) == CMD_POLL || b == CMD_CALL) begin
        case (b)
          CMD_POLL:      mode = RX_WAIT_STATION;
          CMD_TIME_SYNC: mode = RX_TIME_WAIT;
          CMD_CALL:      mode = RX_CALL_WAIT;
          default: ;
        endcase
      end else begin
        case (mode)
          RX_WAIT_STATION: begin
            if (station != 8'd0 && station - 8'd1 == b) r.event_res = EV_POLLED;
            mode = RX_IDLE;
          end
          RX_TIME_WAIT: begin
            if (b == BYTE_BCAST) begin
              mode     = RX_TIME_RECV;
              position = '0;
            end
          end
          RX_CALL_WAIT: begin
            if (b == BYTE_BCAST) begin
              mode     = RX_CALL_RECV;
              position = '0;
            end
          end
          RX_TIME_RECV: take_payload(b, TIME_LEN, EV_TIME_BYTE, EV_TIME_DONE, r);
          RX_CALL_RECV: take_payload(b, CALL_LEN, EV_CALL_BYTE, EV_CALL_DONE, r);
          default: ;
        endcase
      end
      pending_events.push_back(r);
    endfunction

    function void check_event(input logic [2:0] ev, input logic [7:0] data,
                              input logic [6:0] pos);
      acfr_result_t exp_r;
      if (pending_events.size() == 0) begin
        failures++;
        $display("%0t: unexpected result event=%0d data=%0h pos=%0d", $time, ev, data, pos);
        return;
      end
      exp_r = pending_events.pop_front();
      if (ev !== exp_r.event_res) begin
        failures++;
        $display("%0t: event_res expected %0d actual %0d", $time, exp_r.event_res, ev);
      end
      if (data !== exp_r.data_byte) begin
        failures++;
        $display("%0t: data_byte expected %0h actual %0h", $time, exp_r.data_byte, data);
      end
      if (pos !== exp_r.byte_position) begin
        failures++;
        $display("%0t: byte_position expected %0d actual %0d", $time, exp_r.byte_position, pos);
      end
    endfunction
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_data  = '0;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  frame_event_tracker tracker;
  int  cycle_cnt   = 0;
  int  stall_left  = 0;
  int  sent_cnt    = 0;
  bit  idling      = 1'b1;

  addressed_command_frame_receiver #(
    .TIME_FRAME_LEN(TIME_LEN),
    .CALL_FRAME_LEN(CALL_LEN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("addressed_command_frame_receiver test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready)
      tracker.check_event(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[14:8]);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !idling || ($urandom_range(0, 99) >= 11);
    end
  end

  function automatic bit is_command(input logic [7:0] b);
    return (b & CMD_MASK) == CMD_POLL || b == CMD_CALL;
  endfunction

  function automatic logic [7:0] rand_payload();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_command(b) || b == BYTE_END);
    return b;
  endfunction

  function automatic logic [7:0] rand_wait_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_command(b) || b == BYTE_BCAST);
    return b;
  endfunction

  // command pattern that is neither poll, time sync nor call
  function automatic logic [7:0] rand_ignored_cmd();
    logic [7:0] b;
    do b = (8'($urandom_range(0, 255)) & ~CMD_MASK) | CMD_POLL;
    while (b == CMD_POLL || b == CMD_TIME_SYNC);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idling && $urandom_range(0, 99) < 11) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_byte(b);
    sent_cnt++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (tracker.pending_events.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_station(input logic [7:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= STATION_ADDR_OFFSET;
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tracker.station = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int limit);
    int n;
    int ending;
    send_byte(cmd);
    repeat ($urandom_range(0, 2)) send_byte(rand_wait_noise());
    send_byte(BYTE_BCAST);
    n = ($urandom_range(0, 9) < 2) ? limit : $urandom_range(0, (limit > 20) ? 20 : limit);
    for (int k = 0; k < n; k++)
      send_byte(($urandom_range(0, 19) == 0) ? rand_ignored_cmd() : rand_payload());
    ending = $urandom_range(0, 9);
    if (n == limit)
      send_byte((ending < 5) ? BYTE_END : rand_payload());
    else if (ending < 7)
      send_byte(BYTE_END);
    else if (ending < 9)
      send_byte($urandom_range(0, 1) ? CMD_POLL : CMD_CALL);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    int sel;
    stop_at = sent_cnt + count;
    while (sent_cnt < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        send_byte(CMD_POLL);
        send_byte($urandom_range(0, 1) ? tracker.station - 8'd1 : 8'($urandom_range(0, 255)));
      end else if (sel < 55) begin
        send_frame(CMD_TIME_SYNC, TIME_LEN);
      end else if (sel < 80) begin
        send_frame(CMD_CALL, CALL_LEN);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // poll match and mismatch at the reset address
    send_byte(CMD_POLL);
    send_byte(8'h00);
    send_byte(CMD_POLL);
    send_byte(8'h05);
    send_byte(8'h83);
    send_byte(8'hFF);
    // time frame with noise before the broadcast byte
    send_byte(CMD_TIME_SYNC);
    send_byte(8'h22);
    send_byte(BYTE_BCAST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(BYTE_END);
    // call frame cut short by a poll
    send_byte(CMD_CALL);
    send_byte(BYTE_BCAST);
    send_byte(8'h55);
    send_byte(8'h84);
    send_byte(CMD_POLL);
    send_byte(8'h00);
    wait_drained();

    write_station(8'd255);
    stall_left = 200;
    run_random(250);
    wait_drained();

    write_station(8'd0);
    run_random(150);
    wait_drained();

    write_station(8'($urandom_range(1, 254)));
    idling = 1'b0;
    run_random(250);
    idling = 1'b1;
    wait_drained();

    write_station(8'd1);
    run_random(150);
    wait_drained();

    write_station(8'($urandom_range(1, 255)));
    run_random(150);
    wait_drained();

    if (tracker.failures == 0 && tracker.pending_events.size() == 0)
      $display("addressed_command_frame_receiver test passed");
    else
      $display("addressed_command_frame_receiver test failed");
    $finish;
  end

endmodule

// ===== addressed_command_frame_receiver.f =====
rtl/acfr_pkg.sv
rtl/addressed_command_frame_receiver.sv
tb/tb_addressed_command_frame_receiver.sv
